[hw/rtl/slfp_pkg.sv]
package slfp_pkg;

  localparam int FRAME_BYTES = 11;
  localparam int WIN_DEPTH   = FRAME_BYTES - 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STRENGTH = 1'b1;

  localparam logic [7:0]  HEADER_RST       = 8'h59;
  localparam logic [15:0] MIN_STRENGTH_RST = 16'd6;
  localparam logic [15:0] FULL_CIRCLE      = 16'd3600;

  // frame that passed header, checksum and strength checks
  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] strength;
    logic [15:0] angle;
    logic [15:0] quot;
  } frame_t;

endpackage

[hw/rtl/serial_lidar_frame_parser_top.sv]
// The closing byte's frame check is registered into stage 1, the quotient check into out_valid.
// Throughput: one byte per cycle; the two-stage pipeline (frame check plus reciprocal
// multiply, then quotient check) stalls only when the output register is held.
// Reset (rst_n low, synchronous): byte window cleared to zero, header_byte = 0x59,
// min_strength = 6, pipeline emptied.
module serial_lidar_frame_parser_top
  import slfp_pkg::*;
#(
  parameter int BINS       = 240,
  parameter int ANGLE_STEP = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_bin_index,
  output logic [15:0]           out_distance_cm,
  output logic                  out_no_return,
  output logic [15:0]           out_strength,
  output logic                  out_scan_end,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // angle / ANGLE_STEP as (angle * RECIP) >> RECIP_SH, exact for 16-bit angles
  localparam int     RECIP_SH = 16 + $clog2(ANGLE_STEP);
  localparam longint RECIP_L  = ((longint'(1) << RECIP_SH) + ANGLE_STEP - 1) / ANGLE_STEP;
  localparam logic [16:0] RECIP = 17'(RECIP_L);
  localparam int     MUL_W    = 33;
  localparam int     CHK_W    = 16 + $clog2(ANGLE_STEP + 1);
  localparam logic [31:0] LIMIT = 32'(BINS * ANGLE_STEP);

  logic [7:0]  win_r [WIN_DEPTH];
  logic [7:0]  header_r;
  logic [15:0] min_str_r;

  logic        s1_v_r;
  frame_t      s1_r;
  frame_t      s1_nxt;
  logic        out_valid_r;
  logic [7:0]  bin_r;
  logic [15:0] dist_r;
  logic        no_ret_r;
  logic [15:0] str_r;
  logic        scan_end_r;

  logic             in_fire;
  logic             s1_adv;
  logic             s2_ready;
  logic [7:0]       sum;
  logic             frame_ok;
  logic [MUL_W-1:0] recip_prod;
  logic [CHK_W-1:0] chk_prod;
  logic             angle_ok;
  logic [15:0]      quot_m1;

  assign s2_ready = !out_valid_r || out_ready;
  assign s1_adv   = !s1_v_r || s2_ready;
  assign in_ready = s1_adv;
  assign in_fire  = in_valid && in_ready;

  // stage 0: header, checksum, strength, reciprocal multiply
  always_comb begin
    sum = 8'd0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      sum = sum + win_r[i];
    end
    s1_nxt.distance = {win_r[3], win_r[2]};
    s1_nxt.strength = {win_r[5], win_r[4]};
    s1_nxt.angle    = {win_r[7], win_r[6]};
    recip_prod      = MUL_W'(s1_nxt.angle) * MUL_W'(RECIP);
    s1_nxt.quot     = 16'(recip_prod >> RECIP_SH);
    frame_ok = (win_r[0] == header_r) && (win_r[1] == header_r) &&
               (sum == in_rx_byte) && (s1_nxt.strength >= min_str_r);
  end

  // stage 1: quotient must reproduce the angle exactly; angle nonzero and at most BINS * ANGLE_STEP
  assign chk_prod = CHK_W'(s1_r.quot) * CHK_W'(ANGLE_STEP);
  assign angle_ok = (s1_r.angle != 16'd0) && (chk_prod == CHK_W'(s1_r.angle)) &&
                    ({16'd0, s1_r.angle} <= LIMIT);
  assign quot_m1  = s1_r.quot - 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= 8'd0;
      end
      header_r    <= HEADER_RST;
      min_str_r   <= MIN_STRENGTH_RST;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HEADER:       header_r  <= cfg_wdata[7:0];
          REG_MIN_STRENGTH: min_str_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[WIN_DEPTH-1] <= in_rx_byte;
      end
      if (s1_adv) begin
        s1_v_r <= in_fire && frame_ok;
      end
      if (s2_ready) begin
        out_valid_r <= s1_v_r && angle_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (s2_ready && s1_v_r) begin
      bin_r      <= quot_m1[7:0];
      dist_r     <= s1_r.distance;
      no_ret_r   <= (s1_r.distance == 16'd0);
      str_r      <= s1_r.strength;
      scan_end_r <= (s1_r.angle == FULL_CIRCLE);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bin_index   = bin_r;
  assign out_distance_cm = dist_r;
  assign out_no_return   = no_ret_r;
  assign out_strength    = str_r;
  assign out_scan_end    = scan_end_r;

  a_bad_header_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (win_r[0] != header_r)) |=> !s1_v_r)
    else $error("frame with bad header entered pipeline");

  a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_ready) |=> (s1_v_r && $stable(s1_r)))
    else $error("stage 1 lost a request while stalled");

  a_scan_end_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_scan_end) |-> (out_bin_index == 8'(3600 / ANGLE_STEP - 1)))
    else $error("scan end on wrong bin");

endmodule

[dv/serial_lidar_frame_parser_top_test.sv]
module serial_lidar_frame_parser_top_test;
  import slfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BIN_COUNT   = 240;
  localparam int ANGLE_STEP  = 15;
  localparam int ITEM_TARGET = 750;
  localparam int PHASE_BYTES = 125;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic [7:0]  bin;
    logic [15:0] dist_cm;
    logic        no_ret;
    logic [15:0] pwr;
    logic        scan_end;
  } scan_point_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_rx_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_bin_index;
  logic [15:0]           out_distance_cm;
  logic                  out_no_return;
  logic [15:0]           out_strength;
  logic                  out_scan_end;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state
  logic [7:0]  win [WIN_DEPTH];
  logic [7:0]  hdr_val;
  logic [15:0] min_pwr;

  logic [7:0]  byte_q [$];
  scan_point_t scan_q [$];
  int          idle_pct = 20;
  int          errors = 0;
  int          bytes_gen = 0;
  int          cycles = 0;
  bit          in_acc = 1'b0;
  bit          drained = 1'b0;

  serial_lidar_frame_parser_top #(
    .BINS       (BIN_COUNT),
    .ANGLE_STEP (ANGLE_STEP)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bin_index   (out_bin_index),
    .out_distance_cm (out_distance_cm),
    .out_no_return   (out_no_return),
    .out_strength    (out_strength),
    .out_scan_end    (out_scan_end),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // shift one byte into the window and predict the scan point it closes, if any
  task automatic take_byte(input logic [7:0] b);
    logic [7:0]  f [FRAME_BYTES];
    logic [7:0]  sum;
    logic [15:0] d, p, ang;
    scan_point_t pt;
    int          i;
    for (i = 0; i < WIN_DEPTH; i++) f[i] = win[i];
    f[WIN_DEPTH] = b;
    for (i = 0; i < WIN_DEPTH; i++) win[i] = f[i+1];
    if (f[0] != hdr_val || f[1] != hdr_val) return;
    sum = 8'd0;
    for (i = 0; i < WIN_DEPTH; i++) sum = sum + f[i];
    if (sum != f[WIN_DEPTH]) return;
    d   = {f[3], f[2]};
    p   = {f[5], f[4]};
    ang = {f[7], f[6]};
    if (p < min_pwr) return;
    if (ang == 16'd0 || (int'(ang) % ANGLE_STEP) != 0 || int'(ang) > BIN_COUNT * ANGLE_STEP)
      return;
    pt.bin      = 8'(int'(ang) / ANGLE_STEP - 1);
    pt.dist_cm  = d;
    pt.no_ret   = (d == 16'd0);
    pt.pwr      = p;
    pt.scan_end = (ang == FULL_CIRCLE);
    scan_q.push_back(pt);
  endtask

  // acceptance, prediction and result check
  always @(posedge clk) begin
    scan_point_t e;
    in_acc = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (scan_q.size() == 0) begin
        flag_error($sformatf("unexpected result bin=%0d dist=%0d", out_bin_index,
                             out_distance_cm));
      end else begin
        e = scan_q.pop_front();
        if (out_bin_index !== e.bin || out_distance_cm !== e.dist_cm ||
            out_no_return !== e.no_ret || out_strength !== e.pwr ||
            out_scan_end !== e.scan_end)
          flag_error({$sformatf("exp bin=%0d dist=%0d nr=%0b str=%0d end=%0b",
                                e.bin, e.dist_cm, e.no_ret, e.pwr, e.scan_end),
                      $sformatf(", got bin=%0d dist=%0d nr=%0b str=%0d end=%0b",
                                out_bin_index, out_distance_cm, out_no_return,
                                out_strength, out_scan_end)});
      end
    end
    if (in_acc) take_byte(in_rx_byte);
    drained = (byte_q.size() == 0) && !in_valid && (scan_q.size() == 0);
  end

  // request driver and result-side backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_acc) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_rx_byte <= byte_q.pop_front();
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  task automatic wait_idle();
    do @(negedge clk); while (!drained);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_HEADER) hdr_val = val[7:0];
    else if (idx == REG_MIN_STRENGTH) min_pwr = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void push_bytes(input logic [7:0] b);
    byte_q.push_back(b);
    bytes_gen++;
  endfunction

  function automatic void push_frame(input logic [7:0] h0, input logic [7:0] h1,
                                     input logic [15:0] d, input logic [15:0] p,
                                     input logic [15:0] ang, input bit bad_sum);
    logic [7:0] fr [WIN_DEPTH];
    logic [7:0] sum;
    int         i;
    fr[0] = h0;     fr[1] = h1;
    fr[2] = d[7:0]; fr[3] = d[15:8];
    fr[4] = p[7:0]; fr[5] = p[15:8];
    fr[6] = ang[7:0]; fr[7] = ang[15:8];
    fr[8] = 8'($urandom); fr[9] = 8'($urandom);
    sum = 8'd0;
    for (i = 0; i < WIN_DEPTH; i++) begin
      sum = sum + fr[i];
      push_bytes(fr[i]);
    end
    push_bytes(bad_sum ? sum ^ 8'(1 << $urandom_range(0, 7)) : sum);
  endfunction

  function automatic logic [15:0] pick_pwr();
    case ($urandom_range(0, 5))
      0: return min_pwr;
      1: return (min_pwr == 16'd0) ? 16'd0 : min_pwr - 16'd1;
      2: return 16'd0;
      3: return 16'hFFFF;
      default: return ($urandom_range(0, 1) != 0) ? 16'($urandom)
                                                    : min_pwr + 16'($urandom_range(0, 50));
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'(ANGLE_STEP * $urandom_range(1, BIN_COUNT));
    if (r < 78) return FULL_CIRCLE;
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'(ANGLE_STEP * $urandom_range(0, BIN_COUNT) +
                    $urandom_range(1, ANGLE_STEP - 1));
      2: return 16'(BIN_COUNT * ANGLE_STEP + ANGLE_STEP * $urandom_range(1, 100));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void fill_phase();
    int          r, n, k;
    logic [15:0] d;
    n = bytes_gen + PHASE_BYTES;
    while (bytes_gen < n) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: d = 16'd0;
        1: d = 16'hFFFF;
        default: d = 16'($urandom);
      endcase
      if (r < 70) begin
        push_frame(hdr_val, hdr_val, d, pick_pwr(), pick_angle(), 1'b0);
      end else if (r < 85) begin
        // broken frame: bad checksum or one bad header byte
        case ($urandom_range(0, 2))
          0: push_frame(hdr_val, hdr_val, d, pick_pwr(), pick_angle(), 1'b1);
          1: push_frame(~hdr_val, hdr_val, d, pick_pwr(), pick_angle(), 1'b0);
          default: push_frame(hdr_val, hdr_val ^ 8'h10, d, pick_pwr(), pick_angle(), 1'b0);
        endcase
      end else begin
        k = $urandom_range(1, 8);
        repeat (k) push_bytes(8'($urandom));
      end
    end
  endfunction

  initial begin
    logic [7:0]  hdr_tbl [6];
    logic [15:0] pwr_tbl [6];
    int          ph;
    hdr_tbl    = '{8'h59, 8'h00, 8'hFF, 8'h59, 8'hA5, 8'h59};
    pwr_tbl    = '{16'd6, 16'd0, 16'hFFFF, 16'd1000, 16'd0, 16'd6};
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'd0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_HEADER;
    cfg_wdata  = '0;
    for (int i = 0; i < WIN_DEPTH; i++) win[i] = 8'd0;
    hdr_val = HEADER_RST;
    min_pwr = MIN_STRENGTH_RST;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero header lets the cleared window start a frame: no-return, full circle, last bin
    write_reg(REG_HEADER, 16'h0000);
    write_reg(REG_MIN_STRENGTH, 16'h0000);
    push_bytes(8'h00); push_bytes(8'h00);            // distance 0
    push_bytes(8'h00); push_bytes(8'h00);            // strength 0
    push_bytes(8'h10); push_bytes(8'h0E);            // angle 3600
    push_bytes(8'h00); push_bytes(8'h00);
    push_bytes(8'h1E);                                // checksum
    wait_idle();

    write_reg(REG_HEADER, 16'(HEADER_RST));
    write_reg(REG_MIN_STRENGTH, MIN_STRENGTH_RST);
    push_frame(HEADER_RST, HEADER_RST, 16'hFFFF, 16'hFFFF, 16'(ANGLE_STEP), 1'b0);
    push_frame(HEADER_RST, HEADER_RST, 16'h0001, MIN_STRENGTH_RST, FULL_CIRCLE, 1'b0);
    wait_idle();

    // random phases; each drain also holds the sender until all results are back
    ph = 0;
    while (bytes_gen < ITEM_TARGET) begin
      write_reg(REG_HEADER, (ph == 3) ? 16'($urandom_range(0, 255)) : 16'(hdr_tbl[ph % 6]));
      write_reg(REG_MIN_STRENGTH, (ph == 3) ? 16'($urandom) : pwr_tbl[ph % 6]);
      idle_pct = (ph == 2) ? 0 : 20;
      fill_phase();
      wait_idle();
      ph++;
    end

    repeat (10) @(negedge clk);
    if (scan_q.size() != 0) flag_error($sformatf("%0d results never came", scan_q.size()));
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
